// ===== rtl/core/spinf_pkg.sv =====
// Shared types, codes and constants of the SPI NOR flash command sequencer.
package spinf_pkg;

    // Default geometry of the flash part.
    localparam int PAGE_BYTES_DEF   = 256;
    localparam int SECTOR_BYTES_DEF = 4096;

    // Result slots per frame, enough for the most results that one item can cause.
    localparam int MAX_RESULTS = 10;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    // Item function codes.
    localparam logic [2:0] F_READ  = 3'd0;
    localparam logic [2:0] F_ERASE = 3'd1;
    localparam logic [2:0] F_WRITE = 3'd2;
    localparam logic [2:0] F_PROG  = 3'd3;
    localparam logic [2:0] F_ID    = 3'd4;
    localparam logic [2:0] F_DATA  = 3'd5;
    localparam logic [2:0] F_RX    = 3'd6;
    localparam logic [2:0] F_TICK  = 3'd7;

    // Result kinds.
    localparam logic [2:0] K_SEL_ON  = 3'd0;
    localparam logic [2:0] K_SEL_OFF = 3'd1;
    localparam logic [2:0] K_FLASH   = 3'd2;
    localparam logic [2:0] K_HOST    = 3'd3;
    localparam logic [2:0] K_OK      = 3'd4;
    localparam logic [2:0] K_FAIL    = 3'd5;

    // Flash opcodes and the clocking byte.
    localparam logic [7:0] CMD_WREN  = 8'h06;
    localparam logic [7:0] CMD_RDSR  = 8'h05;
    localparam logic [7:0] CMD_PP    = 8'h02;
    localparam logic [7:0] CMD_READ  = 8'h03;
    localparam logic [7:0] CMD_SE    = 8'h20;
    localparam logic [7:0] CMD_RDID  = 8'h9F;
    localparam logic [7:0] DUMMY     = 8'hFF;

    // Configuration register indexes.
    localparam logic [1:0] CFG_PROG_TO  = 2'd0;
    localparam logic [1:0] CFG_ERASE_TO = 2'd1;
    localparam logic [1:0] CFG_EXP_ID   = 2'd2;

    // Configuration reset values.
    localparam logic [15:0] PROG_TO_RST  = 16'd100;
    localparam logic [15:0] ERASE_TO_RST = 16'd400;
    localparam logic [23:0] EXP_ID_RST   = 24'hEF4013;

    typedef struct packed {
        logic [15:0] prog_timeout_ms;
        logic [15:0] erase_timeout_ms;
        logic [23:0] expected_id;
    } t_cfg;

    typedef struct packed {
        logic [2:0]  func;
        logic [23:0] addr;
        logic [23:0] length;
        logic [7:0]  data_byte;
        logic        link_error;
    } t_item;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] value;
    } t_result;

    typedef struct packed {
        logic [CNT_W-1:0]                count;
        t_result [MAX_RESULTS-1:0]       ent;
    } t_frame;

    function automatic t_result f_res(input logic [2:0] kind, input logic [7:0] value);
        t_result r;
        r.kind  = kind;
        r.value = value;
        return r;
    endfunction

endpackage

// ===== rtl/core/spinf_cfg.sv =====
// Configuration registers: timeouts and the expected JEDEC identifier.
module spinf_cfg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_index,
    input  logic [23:0]      i_cfg_data,
    output spinf_pkg::t_cfg  o_cfg
);
    import spinf_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.prog_timeout_ms  <= PROG_TO_RST;
            r_cfg.erase_timeout_ms <= ERASE_TO_RST;
            r_cfg.expected_id      <= EXP_ID_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_PROG_TO:  r_cfg.prog_timeout_ms  <= i_cfg_data[15:0];
                CFG_ERASE_TO: r_cfg.erase_timeout_ms <= i_cfg_data[15:0];
                CFG_EXP_ID:   r_cfg.expected_id      <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/core/spinf_seq.sv =====
// Sequencer state and the one-step logic that turns an item into a result frame.
module spinf_seq #(
    parameter int PAGE_BYTES   = spinf_pkg::PAGE_BYTES_DEF,
    parameter int SECTOR_BYTES = spinf_pkg::SECTOR_BYTES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  spinf_pkg::t_item  i_item,
    input  spinf_pkg::t_cfg   i_cfg,
    output spinf_pkg::t_frame o_frame
);
    import spinf_pkg::*;

    localparam int CW = $clog2(PAGE_BYTES + 1);
    localparam logic [23:0] PAGE_MASK = 24'(PAGE_BYTES - 1);
    localparam logic [23:0] SEC_MASK  = 24'(SECTOR_BYTES - 1);

    typedef enum logic [5:0] {
        PH_IDLE      = 6'b000001,
        PH_READ_RX   = 6'b000010,
        PH_PROG_DATA = 6'b000100,
        PH_POLL_WAIT = 6'b001000,
        PH_POLL_RX   = 6'b010000,
        PH_ID_RX     = 6'b100000
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [2:0]  r_op, n_op;
    logic [23:0] r_cur, n_cur;
    logic [23:0] r_left, n_left;
    logic [CW-1:0] r_chunk, n_chunk;
    logic [15:0] r_elapsed, n_elapsed;
    logic [23:0] r_id, n_id;
    logic [1:0]  r_reply, n_reply;

    t_frame      n_frame;

    // Page start shared by a new write or program and the next page of a write.
    logic [23:0]   pg_addr, pg_len;
    logic [CW-1:0] pg_room, pg_chunk;
    t_result [7:0] pg_head;

    logic [23:0] left_dec, sec_addr, id_next;
    logic [1:0]  reply_inc;
    logic [CW-1:0] chunk_dec;
    logic [15:0] limit;
    logic        prog_bad;

    function automatic t_result [7:0] f_page_head(input logic [23:0] a);
        t_result [7:0] h;
        h[0] = f_res(K_SEL_ON, 8'h00);
        h[1] = f_res(K_FLASH, CMD_WREN);
        h[2] = f_res(K_SEL_OFF, 8'h00);
        h[3] = f_res(K_SEL_ON, 8'h00);
        h[4] = f_res(K_FLASH, CMD_PP);
        h[5] = f_res(K_FLASH, a[23:16]);
        h[6] = f_res(K_FLASH, a[15:8]);
        h[7] = f_res(K_FLASH, a[7:0]);
        return h;
    endfunction

    always_comb begin
        pg_addr  = (r_phase == PH_IDLE) ? i_item.addr   : r_cur;
        pg_len   = (r_phase == PH_IDLE) ? i_item.length : r_left;
        pg_room  = CW'(PAGE_BYTES) - CW'(pg_addr & PAGE_MASK);
        pg_chunk = (pg_len < 24'(pg_room)) ? pg_len[CW-1:0] : pg_room;
        pg_head  = f_page_head(pg_addr);

        left_dec  = r_left - 24'd1;
        chunk_dec = r_chunk - CW'(1);
        sec_addr  = i_item.addr & ~SEC_MASK;
        id_next   = {r_id[15:0], i_item.data_byte};
        reply_inc = r_reply + 2'd1;
        limit     = (r_op == F_ERASE) ? i_cfg.erase_timeout_ms : i_cfg.prog_timeout_ms;
        prog_bad  = (i_item.length == 24'd0) || (i_item.length > 24'(PAGE_BYTES)) ||
                    (({1'b0, i_item.addr & PAGE_MASK} + {1'b0, i_item.length})
                        > 25'(PAGE_BYTES));
    end

    always_comb begin
        n_phase   = r_phase;
        n_op      = r_op;
        n_cur     = r_cur;
        n_left    = r_left;
        n_chunk   = r_chunk;
        n_elapsed = r_elapsed;
        n_id      = r_id;
        n_reply   = r_reply;
        n_frame   = '0;

        unique case (i_item.func) inside
            F_READ, F_ERASE, F_WRITE, F_PROG, F_ID: begin
                // Requests are taken only when no operation is running.
                if (r_phase == PH_IDLE) begin
                    n_op = i_item.func;
                    unique case (i_item.func) inside
                        F_READ: begin
                            if (i_item.length == 24'd0) begin
                                n_frame.ent[0] = f_res(K_OK, 8'h00);
                                n_frame.count  = CNT_W'(1);
                            end else begin
                                n_cur  = i_item.addr;
                                n_left = i_item.length;
                                n_frame.ent[0] = f_res(K_SEL_ON, 8'h00);
                                n_frame.ent[1] = f_res(K_FLASH, CMD_READ);
                                n_frame.ent[2] = f_res(K_FLASH, i_item.addr[23:16]);
                                n_frame.ent[3] = f_res(K_FLASH, i_item.addr[15:8]);
                                n_frame.ent[4] = f_res(K_FLASH, i_item.addr[7:0]);
                                n_frame.ent[5] = f_res(K_FLASH, DUMMY);
                                n_frame.count  = CNT_W'(6);
                                n_phase = PH_READ_RX;
                            end
                        end
                        F_ERASE: begin
                            n_cur = sec_addr;
                            n_frame.ent[0] = f_res(K_SEL_ON, 8'h00);
                            n_frame.ent[1] = f_res(K_FLASH, CMD_WREN);
                            n_frame.ent[2] = f_res(K_SEL_OFF, 8'h00);
                            n_frame.ent[3] = f_res(K_SEL_ON, 8'h00);
                            n_frame.ent[4] = f_res(K_FLASH, CMD_SE);
                            n_frame.ent[5] = f_res(K_FLASH, sec_addr[23:16]);
                            n_frame.ent[6] = f_res(K_FLASH, sec_addr[15:8]);
                            n_frame.ent[7] = f_res(K_FLASH, sec_addr[7:0]);
                            n_frame.ent[8] = f_res(K_SEL_OFF, 8'h00);
                            n_frame.count  = CNT_W'(9);
                            n_elapsed = 16'd0;
                            n_phase   = PH_POLL_WAIT;
                        end
                        F_WRITE, F_PROG: begin
                            if ((i_item.func == F_WRITE) && (i_item.length == 24'd0)) begin
                                n_frame.ent[0] = f_res(K_OK, 8'h00);
                                n_frame.count  = CNT_W'(1);
                            end else if ((i_item.func == F_PROG) && prog_bad) begin
                                n_frame.ent[0] = f_res(K_FAIL, 8'h00);
                                n_frame.count  = CNT_W'(1);
                            end else begin
                                n_cur   = i_item.addr;
                                n_left  = i_item.length;
                                n_chunk = pg_chunk;
                                for (int i = 0; i < 8; i++) begin
                                    n_frame.ent[i] = pg_head[i];
                                end
                                n_frame.count = CNT_W'(8);
                                n_phase = PH_PROG_DATA;
                            end
                        end
                        default: begin
                            n_id    = 24'd0;
                            n_reply = 2'd0;
                            n_frame.ent[0] = f_res(K_SEL_ON, 8'h00);
                            n_frame.ent[1] = f_res(K_FLASH, CMD_RDID);
                            n_frame.ent[2] = f_res(K_FLASH, DUMMY);
                            n_frame.count  = CNT_W'(3);
                            n_phase = PH_ID_RX;
                        end
                    endcase
                end
            end
            F_DATA: begin
                if (r_phase == PH_PROG_DATA) begin
                    n_frame.ent[0] = f_res(K_FLASH, i_item.data_byte);
                    n_cur   = r_cur + 24'd1;
                    n_left  = left_dec;
                    n_chunk = chunk_dec;
                    if (chunk_dec == '0) begin
                        n_frame.ent[1] = f_res(K_SEL_OFF, 8'h00);
                        n_frame.count  = CNT_W'(2);
                        n_elapsed = 16'd0;
                        n_phase   = PH_POLL_WAIT;
                    end else begin
                        n_frame.count = CNT_W'(1);
                    end
                end
            end
            F_RX: begin
                if ((r_phase == PH_READ_RX) || (r_phase == PH_POLL_RX) ||
                    (r_phase == PH_ID_RX)) begin
                    if (i_item.link_error) begin
                        n_frame.ent[0] = f_res(K_SEL_OFF, 8'h00);
                        n_frame.ent[1] = f_res(K_FAIL, 8'h00);
                        n_frame.count  = CNT_W'(2);
                        n_phase = PH_IDLE;
                    end else if (r_phase == PH_READ_RX) begin
                        n_frame.ent[0] = f_res(K_HOST, i_item.data_byte);
                        n_left = left_dec;
                        n_cur  = r_cur + 24'd1;
                        if (left_dec != 24'd0) begin
                            n_frame.ent[1] = f_res(K_FLASH, DUMMY);
                            n_frame.count  = CNT_W'(2);
                        end else begin
                            n_frame.ent[1] = f_res(K_SEL_OFF, 8'h00);
                            n_frame.ent[2] = f_res(K_OK, 8'h00);
                            n_frame.count  = CNT_W'(3);
                            n_phase = PH_IDLE;
                        end
                    end else if (r_phase == PH_ID_RX) begin
                        n_id    = id_next;
                        n_reply = reply_inc;
                        if (reply_inc != 2'd3) begin
                            n_frame.ent[0] = f_res(K_FLASH, DUMMY);
                            n_frame.count  = CNT_W'(1);
                        end else begin
                            n_reply = 2'd0;
                            n_frame.ent[0] = f_res(K_SEL_OFF, 8'h00);
                            n_frame.ent[1] = f_res((id_next == i_cfg.expected_id) ?
                                                   K_OK : K_FAIL, 8'h00);
                            n_frame.count  = CNT_W'(2);
                            n_phase = PH_IDLE;
                        end
                    end else begin
                        // Status byte closes the poll frame.
                        n_frame.ent[0] = f_res(K_SEL_OFF, 8'h00);
                        if (i_item.data_byte[0]) begin
                            n_frame.count = CNT_W'(1);
                            n_phase = PH_POLL_WAIT;
                        end else if ((r_op == F_WRITE) && (r_left != 24'd0)) begin
                            n_chunk = pg_chunk;
                            for (int i = 0; i < 8; i++) begin
                                n_frame.ent[i+1] = pg_head[i];
                            end
                            n_frame.count = CNT_W'(9);
                            n_phase = PH_PROG_DATA;
                        end else begin
                            n_frame.ent[1] = f_res(K_OK, 8'h00);
                            n_frame.count  = CNT_W'(2);
                            n_phase = PH_IDLE;
                        end
                    end
                end
            end
            default: begin
                if (r_phase == PH_POLL_WAIT) begin
                    if (r_elapsed >= limit) begin
                        n_frame.ent[0] = f_res(K_FAIL, 8'h00);
                        n_frame.count  = CNT_W'(1);
                        n_phase = PH_IDLE;
                    end else begin
                        n_elapsed = r_elapsed + 16'd1;
                        n_frame.ent[0] = f_res(K_SEL_ON, 8'h00);
                        n_frame.ent[1] = f_res(K_FLASH, CMD_RDSR);
                        n_frame.ent[2] = f_res(K_FLASH, DUMMY);
                        n_frame.count  = CNT_W'(3);
                        n_phase = PH_POLL_RX;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_op      <= '0;
            r_cur     <= '0;
            r_left    <= '0;
            r_chunk   <= '0;
            r_elapsed <= '0;
            r_id      <= '0;
            r_reply   <= '0;
        end else if (i_fire) begin
            r_phase   <= n_phase;
            r_op      <= n_op;
            r_cur     <= n_cur;
            r_left    <= n_left;
            r_chunk   <= n_chunk;
            r_elapsed <= n_elapsed;
            r_id      <= n_id;
            r_reply   <= n_reply;
        end
    end

    assign o_frame = n_frame;

endmodule

// ===== rtl/core/spinf_outq.sv =====
// Result register: holds one item's result frame and hands it out one result at a time.
module spinf_outq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  spinf_pkg::t_frame i_frame,
    output logic              o_can_load,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [2:0]        o_kind,
    output logic [7:0]        o_value,
    output logic              o_last
);
    import spinf_pkg::*;

    t_result [MAX_RESULTS-1:0] r_ent;
    logic [CNT_W-1:0]          r_left;
    logic                      take;

    assign take       = (r_left != '0) && !i_stall;
    assign o_can_load = (r_left == '0) || ((r_left == CNT_W'(1)) && take);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
        end else if (i_load) begin
            r_left <= i_frame.count;
        end else if (take) begin
            r_left <= r_left - CNT_W'(1);
        end
    end

    // Payload shifts toward slot zero as results leave.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_ent <= i_frame.ent;
        end else if (take) begin
            for (int i = 0; i < MAX_RESULTS - 1; i++) begin
                r_ent[i] <= r_ent[i+1];
            end
            r_ent[MAX_RESULTS-1] <= '0;
        end
    end

    assign o_valid = (r_left != '0);
    assign o_kind  = r_ent[0].kind;
    assign o_value = r_ent[0].value;
    assign o_last  = (r_left == CNT_W'(1));

endmodule

// ===== rtl/core/spi_nor_flash_command_sequencer_unit.sv =====
// Top level of the SPI NOR flash command sequencer.
// Each input item is one event: a host request (read, sector erase, write, page program,
// ID check), a host data byte, a byte received from the flash, or a millisecond tick.
// The block answers with a short ordered list of results: chip-select edges, bytes to
// shift out to the flash, bytes for the host, and an ok or fail verdict that always
// comes last for a request. An accepted item waits in the input register while the
// sequencer builds the whole result list combinationally; once the result register is
// free, the list is loaded there and the sequencer state steps at the same edge. The result
// register sends one result per cycle while the receiver does not stall; an item causes
// at most nine results. A new item is accepted in every cycle while each item causes at
// most one result and the receiver does not stall; items that cause none pass at one per
// cycle while the result register is free. Requests that arrive while an operation runs,
// data bytes outside a program frame, unexpected received bytes and ticks outside polling
// are dropped without results. Configuration registers (index 0: program timeout in ms,
// 1: erase timeout in ms, 2: expected JEDEC id) must be written only while idle; the
// block itself does not enforce this. Page and sector sizes must be powers of two.
module spi_nor_flash_command_sequencer_unit #(
    parameter int PAGE_BYTES   = spinf_pkg::PAGE_BYTES_DEF,
    parameter int SECTOR_BYTES = spinf_pkg::SECTOR_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write port.
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data,
    // Input item channel.
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_func,
    input  logic [23:0] i_addr,
    input  logic [23:0] i_length,
    input  logic [7:0]  i_data_byte,
    input  logic        i_link_error,
    // Result item channel.
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_kind,
    output logic [7:0]  o_value,
    output logic        o_last
);
    import spinf_pkg::*;

    t_cfg   cfg;
    t_frame frame;
    t_item  r_item;
    logic   r_in_valid;
    logic   can_load;
    logic   fire;

    // The input register hands its item to the sequencer once the result register
    // can take the new frame; the source is stalled while a held item cannot go yet.
    assign fire    = r_in_valid && can_load;
    assign o_stall = r_in_valid && !can_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_valid && !o_stall) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_item.func       <= i_func;
            r_item.addr       <= i_addr;
            r_item.length     <= i_length;
            r_item.data_byte  <= i_data_byte;
            r_item.link_error <= i_link_error;
        end
    end

    spinf_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    spinf_seq #(
        .PAGE_BYTES   (PAGE_BYTES),
        .SECTOR_BYTES (SECTOR_BYTES)
    ) u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_item  (r_item),
        .i_cfg   (cfg),
        .o_frame (frame)
    );

    spinf_outq u_outq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (fire),
        .i_frame    (frame),
        .o_can_load (can_load),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_kind     (o_kind),
        .o_value    (o_value),
        .o_last     (o_last)
    );

endmodule

// ===== rtl/core/spinf_checker.sv =====
// Port-level checks of the sequencer and their attachment to the top level.
module spinf_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_stall,
    input logic       o_stall,
    input logic [2:0] o_kind,
    input logic [7:0] o_value,
    input logic       o_last
);
    import spinf_pkg::*;

    // A stalled result holds until taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_kind) && $stable(o_value) &&
                               $stable(o_last))
        else $error("stalled result changed");

    // With no result pending, the block always takes an item.
    a_no_stall_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_stall)
        else $error("input stalled while output empty");

    // A verdict always closes the results of its item.
    a_verdict_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_kind == K_OK || o_kind == K_FAIL) |-> o_last)
        else $error("verdict not last");

    // Select edges and verdicts carry no byte.
    a_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_kind == K_SEL_ON || o_kind == K_SEL_OFF || o_kind == K_OK ||
                    o_kind == K_FAIL) |-> o_value == 8'h00)
        else $error("nonzero value on a non-byte result");

endmodule

bind spi_nor_flash_command_sequencer_unit spinf_checker u_chk (.*);

// ===== verif/spi_nor_flash_command_sequencer_unit_tb.sv =====
// Self-checking testbench for the SPI NOR flash command sequencer.
`timescale 1ns / 1ps

module spi_nor_flash_command_sequencer_unit_tb;
    import spinf_pkg::*;

    localparam int PAGE_SZ    = PAGE_BYTES_DEF;
    localparam int SECTOR_SZ  = SECTOR_BYTES_DEF;
    // Cycles without any accepted item on either channel before the run is abandoned.
    // The slowest correct case is a nine-result item behind a heavily stalling receiver.
    localparam int STALL_LIMIT = 2000;
    // Cycles the block may still spend on an item that produced no result.
    localparam int SETTLE_CYCLES = 8;

    // Sequencer phases as the predictor tracks them.
    typedef enum logic [2:0] {
        SQ_IDLE,
        SQ_READ_RX,
        SQ_PROG_DATA,
        SQ_POLL_WAIT,
        SQ_POLL_RX,
        SQ_ID_RX
    } t_seq_phase;

    // One predicted result item: what the block should emit and whether it closes the
    // list that its input item caused.
    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] value;
        logic       last;
    } t_action;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic [23:0] i_cfg_data;
    logic        i_valid;
    logic        o_stall;
    logic [2:0]  i_func;
    logic [23:0] i_addr;
    logic [23:0] i_length;
    logic [7:0]  i_data_byte;
    logic        i_link_error;
    logic        o_valid;
    logic        i_stall;
    logic [2:0]  o_kind;
    logic [7:0]  o_value;
    logic        o_last;

    // Predictor copy of the configuration registers.
    logic [15:0] cfg_prog_to;
    logic [15:0] cfg_erase_to;
    logic [23:0] cfg_id;

    // Predictor copy of the sequencer state.
    t_seq_phase  m_phase;
    logic [2:0]  m_op;
    logic [23:0] m_addr;
    logic [23:0] m_left;
    logic [8:0]  m_chunk;
    logic [15:0] m_elapsed;
    logic [23:0] m_id;
    logic [1:0]  m_replies;

    // Results of the item being predicted, then the store of all results still due.
    t_action step_acts[$];
    t_action exp_actions[$];
    t_action want;

    int tx_idle_pct;
    int rx_idle_pct;
    int items_sent;
    int results_checked;
    int mismatches;
    int idle_cycles;

    spi_nor_flash_command_sequencer_unit #(
        .PAGE_BYTES   (PAGE_SZ),
        .SECTOR_BYTES (SECTOR_SZ)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_func       (i_func),
        .i_addr       (i_addr),
        .i_length     (i_length),
        .i_data_byte  (i_data_byte),
        .i_link_error (i_link_error),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_kind       (o_kind),
        .o_value      (o_value),
        .o_last       (o_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor of the flash actions.
    // ------------------------------------------------------------------

    function automatic void reset_predictor();
        cfg_prog_to  = PROG_TO_RST;
        cfg_erase_to = ERASE_TO_RST;
        cfg_id       = EXP_ID_RST;
        m_phase      = SQ_IDLE;
        m_op         = 3'd0;
        m_addr       = '0;
        m_left       = '0;
        m_chunk      = '0;
        m_elapsed    = '0;
        m_id         = '0;
        m_replies    = '0;
    endfunction

    function automatic void emit(input logic [2:0] kind, input logic [7:0] value);
        if (step_acts.size() < MAX_RESULTS) begin
            step_acts.push_back('{kind, value, 1'b0});
        end
    endfunction

    function automatic void emit_addr(input logic [23:0] a);
        emit(K_FLASH, a[23:16]);
        emit(K_FLASH, a[15:8]);
        emit(K_FLASH, a[7:0]);
    endfunction

    function automatic void close_op(input logic ok);
        emit(ok ? K_OK : K_FAIL, 8'h00);
        m_phase = SQ_IDLE;
    endfunction

    function automatic void emit_wren();
        emit(K_SEL_ON, 8'h00);
        emit(K_FLASH, CMD_WREN);
        emit(K_SEL_OFF, 8'h00);
    endfunction

    // A program chunk never runs past the end of the page that holds its first byte.
    function automatic void begin_page();
        int room;
        room = PAGE_SZ - int'(m_addr % PAGE_SZ);
        m_chunk = (int'(m_left) < room) ? 9'(m_left) : 9'(room);
        emit_wren();
        emit(K_SEL_ON, 8'h00);
        emit(K_FLASH, CMD_PP);
        emit_addr(m_addr);
        m_phase = SQ_PROG_DATA;
    endfunction

    function automatic void start_request(input t_item it);
        m_op = it.func;
        case (it.func)
            F_READ: begin
                if (it.length == 0) begin
                    close_op(1'b1);
                end else begin
                    m_addr = it.addr;
                    m_left = it.length;
                    emit(K_SEL_ON, 8'h00);
                    emit(K_FLASH, CMD_READ);
                    emit_addr(it.addr);
                    emit(K_FLASH, DUMMY);
                    m_phase = SQ_READ_RX;
                end
            end
            F_ERASE: begin
                m_addr = it.addr - 24'(it.addr % SECTOR_SZ);
                emit_wren();
                emit(K_SEL_ON, 8'h00);
                emit(K_FLASH, CMD_SE);
                emit_addr(m_addr);
                emit(K_SEL_OFF, 8'h00);
                m_elapsed = '0;
                m_phase = SQ_POLL_WAIT;
            end
            F_WRITE: begin
                if (it.length == 0) begin
                    close_op(1'b1);
                end else begin
                    m_addr = it.addr;
                    m_left = it.length;
                    begin_page();
                end
            end
            F_PROG: begin
                if (it.length == 0 || it.length > PAGE_SZ ||
                    int'(it.addr % PAGE_SZ) + int'(it.length) > PAGE_SZ) begin
                    close_op(1'b0);
                end else begin
                    m_addr = it.addr;
                    m_left = it.length;
                    begin_page();
                end
            end
            default: begin
                m_id = '0;
                m_replies = '0;
                emit(K_SEL_ON, 8'h00);
                emit(K_FLASH, CMD_RDID);
                emit(K_FLASH, DUMMY);
                m_phase = SQ_ID_RX;
            end
        endcase
    endfunction

    function automatic void take_reply(input logic [7:0] b, input logic err);
        if (m_phase != SQ_READ_RX && m_phase != SQ_POLL_RX && m_phase != SQ_ID_RX) begin
            return;
        end
        if (err) begin
            emit(K_SEL_OFF, 8'h00);
            close_op(1'b0);
            return;
        end
        case (m_phase)
            SQ_READ_RX: begin
                emit(K_HOST, b);
                m_left = m_left - 1'b1;
                m_addr = m_addr + 1'b1;
                if (m_left != 0) begin
                    emit(K_FLASH, DUMMY);
                end else begin
                    emit(K_SEL_OFF, 8'h00);
                    close_op(1'b1);
                end
            end
            SQ_ID_RX: begin
                m_id = {m_id[15:0], b};
                m_replies = m_replies + 1'b1;
                if (m_replies < 3) begin
                    emit(K_FLASH, DUMMY);
                end else begin
                    m_replies = '0;
                    emit(K_SEL_OFF, 8'h00);
                    close_op(m_id == cfg_id);
                end
            end
            default: begin
                // The status byte closes the poll frame; bit 0 is the busy flag.
                emit(K_SEL_OFF, 8'h00);
                if (b[0]) begin
                    m_phase = SQ_POLL_WAIT;
                end else if (m_op == F_WRITE && m_left != 0) begin
                    begin_page();
                end else begin
                    close_op(1'b1);
                end
            end
        endcase
    endfunction

    function automatic void take_tick();
        logic [15:0] limit;
        limit = (m_op == F_ERASE) ? cfg_erase_to : cfg_prog_to;
        if (m_phase != SQ_POLL_WAIT) begin
            return;
        end
        if (m_elapsed >= limit) begin
            close_op(1'b0);
            return;
        end
        m_elapsed = m_elapsed + 1'b1;
        emit(K_SEL_ON, 8'h00);
        emit(K_FLASH, CMD_RDSR);
        emit(K_FLASH, DUMMY);
        m_phase = SQ_POLL_RX;
    endfunction

    // Steps the predictor by one accepted item and files the results it causes.
    function automatic void predict_flash_actions(input t_item it);
        step_acts.delete();
        case (it.func)
            F_DATA: begin
                if (m_phase == SQ_PROG_DATA) begin
                    emit(K_FLASH, it.data_byte);
                    m_addr  = m_addr + 1'b1;
                    m_left  = m_left - 1'b1;
                    m_chunk = m_chunk - 1'b1;
                    if (m_chunk == 0) begin
                        emit(K_SEL_OFF, 8'h00);
                        m_elapsed = '0;
                        m_phase = SQ_POLL_WAIT;
                    end
                end
            end
            F_RX:    take_reply(it.data_byte, it.link_error);
            F_TICK:  take_tick();
            default: begin
                if (m_phase == SQ_IDLE) begin
                    start_request(it);
                end
            end
        endcase
        if (step_acts.size() != 0) begin
            step_acts[step_acts.size() - 1].last = 1'b1;
        end
        foreach (step_acts[k]) begin
            exp_actions.push_back(step_acts[k]);
        end
    endfunction

    // ------------------------------------------------------------------
    // Driving.
    // ------------------------------------------------------------------

    function automatic t_item mk(input logic [2:0] func, input logic [23:0] addr,
                                 input logic [23:0] length, input logic [7:0] data,
                                 input logic err);
        t_item it;
        it.func       = func;
        it.addr       = addr;
        it.length     = length;
        it.data_byte  = data;
        it.link_error = err;
        return it;
    endfunction

    // Sends one item and returns in the time step in which it was accepted. Valid is
    // left high there, so that a following item can go out back to back; anything
    // else that lets time pass drops valid first.
    task automatic send_item(input t_item it);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_func       <= it.func;
        i_addr       <= it.addr;
        i_length     <= it.length;
        i_data_byte  <= it.data_byte;
        i_link_error <= it.link_error;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
        predict_flash_actions(it);
        items_sent++;
    endtask

    // Lowers valid, waits until every predicted result has come out and gives the
    // block time to finish an item that produced none.
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (exp_actions.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [1:0] index, input logic [23:0] data);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        case (index)
            CFG_PROG_TO:  cfg_prog_to  = data[15:0];
            CFG_ERASE_TO: cfg_erase_to = data[15:0];
            CFG_EXP_ID:   cfg_id       = data;
            default: ;
        endcase
    endtask

    // Feeds whatever the running operation waits for until it has ended. Received
    // bytes carry random content; link errors and busy status appear at random, and
    // long operations are cut short by a forced link error. A few items are pure noise.
    task automatic drive_to_idle();
        int          steps;
        logic [7:0]  b;
        logic        err;
        steps = 0;
        while (m_phase != SQ_IDLE) begin
            steps++;
            b   = 8'($urandom);
            err = ($urandom_range(99) < 3);
            if ($urandom_range(99) < 5) begin
                send_item(mk(3'($urandom), 24'($urandom), 24'($urandom), b, 1'($urandom)));
            end else begin
                case (m_phase)
                    SQ_READ_RX: begin
                        send_item(mk(F_RX, 24'($urandom), 24'($urandom), b,
                                     err || steps > 24));
                    end
                    SQ_ID_RX: begin
                        // Mostly the expected id, so that both verdicts show up.
                        if ($urandom_range(99) < 60) begin
                            b = 8'(cfg_id >> (8 * (2 - m_replies)));
                        end
                        send_item(mk(F_RX, 24'($urandom), 24'($urandom), b, err));
                    end
                    SQ_PROG_DATA: begin
                        send_item(mk(F_DATA, 24'($urandom), 24'($urandom), b, 1'($urandom)));
                    end
                    SQ_POLL_WAIT: begin
                        send_item(mk(F_TICK, 24'($urandom), 24'($urandom), b, 1'($urandom)));
                    end
                    default: begin
                        b[0] = ($urandom_range(99) < 35);
                        err  = err || steps > 40 || (m_op == F_WRITE && m_left > 32);
                        send_item(mk(F_RX, 24'($urandom), 24'($urandom), b, err));
                    end
                endcase
            end
        end
    endtask

    // Starts one request with random content, mostly well formed and of small sizes.
    task automatic launch_request();
        logic [2:0]  f;
        logic [23:0] a;
        logic [23:0] n;
        int          r;
        int          off;
        f = 3'($urandom_range(int'(F_READ), int'(F_ID)));
        a = 24'($urandom);
        n = 24'($urandom);
        r = $urandom_range(99);
        case (f)
            F_READ: begin
                if (r < 10) begin
                    n = '0;
                end else if (r >= 15) begin
                    n = 24'($urandom_range(1, 6));
                end
            end
            F_WRITE: begin
                // Page-end starts split the write; huge lengths only start there.
                if ($urandom_range(1) == 1 || (r >= 10 && r < 15)) begin
                    a[7:0] = 8'(PAGE_SZ - $urandom_range(1, 8));
                end
                if (r < 10) begin
                    n = '0;
                end else if (r >= 15) begin
                    n = 24'($urandom_range(1, 12));
                end
            end
            F_PROG: begin
                off = int'(a % PAGE_SZ);
                if (r < 5) begin
                    n = '0;
                end else if (r < 12) begin
                    n = 24'(PAGE_SZ - off + $urandom_range(1, 4));
                end else if (r >= 20) begin
                    n = 24'($urandom_range(1, (PAGE_SZ - off < 8) ? PAGE_SZ - off : 8));
                end
            end
            default: ;
        endcase
        send_item(mk(f, a, n, 8'($urandom), 1'($urandom)));
    endtask

    // ------------------------------------------------------------------
    // Checking, receiver stalls and watchdog.
    // ------------------------------------------------------------------

    // Each result accepted at this edge is compared with the oldest prediction. The
    // stall for the next cycle is drawn in the same block.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (exp_actions.size() == 0) begin
                $error("unexpected result: kind %0d value 0x%02h last %0b",
                       o_kind, o_value, o_last);
                mismatches++;
            end else begin
                want = exp_actions.pop_front();
                results_checked++;
                if (o_kind !== want.kind) begin
                    $error("kind: expected %0d, got %0d", want.kind, o_kind);
                    mismatches++;
                end
                if (o_value !== want.value) begin
                    $error("value: expected 0x%02h, got 0x%02h", want.value, o_value);
                    mismatches++;
                end
                if (o_last !== want.last) begin
                    $error("last: expected %0b, got %0b", want.last, o_last);
                    mismatches++;
                end
            end
        end
        i_stall <= ($urandom_range(99) < rx_idle_pct);
    end

    // The watchdog restarts on every accepted item on either channel.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Timeout: no item moved for %0d cycles", STALL_LIMIT);
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Directed tests.
    // ------------------------------------------------------------------

    // Zero-length read and write succeed at once; a page program of zero length,
    // of more than a page, or crossing a page boundary fails with no flash traffic.
    task automatic test_zero_length_requests();
        send_item(mk(F_READ, 24'h000000, 24'h000000, 8'h00, 1'b0));
        send_item(mk(F_WRITE, 24'hFFFFFF, 24'h000000, 8'hFF, 1'b1));
        send_item(mk(F_PROG, 24'h000000, 24'h000000, 8'h00, 1'b0));
        send_item(mk(F_PROG, 24'h000000, 24'(PAGE_SZ + 1), 8'h00, 1'b0));
        send_item(mk(F_PROG, 24'hFFFFF0, 24'd17, 8'h00, 1'b0));
    endtask

    // A tick outside polling and a received byte with nothing awaited are dropped.
    task automatic test_stray_events();
        send_item(mk(F_TICK, 24'hFFFFFF, 24'hFFFFFF, 8'hFF, 1'b1));
        send_item(mk(F_RX, 24'h000000, 24'h000000, 8'h00, 1'b0));
    endtask

    // A read of the largest length at the top address is cut short by a link error.
    // A request and a data byte that arrive during the read are dropped.
    task automatic test_read_abort();
        send_item(mk(F_READ, 24'hFFFFFF, 24'hFFFFFF, 8'h00, 1'b0));
        send_item(mk(F_RX, 24'h000000, 24'h000000, 8'h00, 1'b0));
        send_item(mk(F_ID, 24'h000000, 24'h000000, 8'h00, 1'b0));
        send_item(mk(F_DATA, 24'h000000, 24'h000000, 8'h5A, 1'b0));
        send_item(mk(F_RX, 24'h000000, 24'h000000, 8'hFF, 1'b1));
    endtask

    // The id check after reset matches the reset value of the expected id.
    task automatic test_id_check();
        send_item(mk(F_ID, 24'h000000, 24'h000000, 8'h00, 1'b0));
        send_item(mk(F_RX, 24'h000000, 24'h000000, cfg_id[23:16], 1'b0));
        send_item(mk(F_RX, 24'h000000, 24'h000000, cfg_id[15:8], 1'b0));
        send_item(mk(F_RX, 24'h000000, 24'h000000, cfg_id[7:0], 1'b0));
    endtask

    // Erase at the top address rounds down to the sector; one busy poll, then ready.
    task automatic test_erase_polling();
        send_item(mk(F_ERASE, 24'hFFFFFF, 24'h000000, 8'h00, 1'b0));
        send_item(mk(F_TICK, 24'h000000, 24'h000000, 8'h00, 1'b0));
        send_item(mk(F_RX, 24'h000000, 24'h000000, 8'h01, 1'b0));
        send_item(mk(F_TICK, 24'h000000, 24'h000000, 8'h00, 1'b0));
        send_item(mk(F_RX, 24'h000000, 24'h000000, 8'h00, 1'b0));
    endtask

    // A two-byte write at the top address splits into two pages and wraps to zero.
    task automatic test_write_page_wrap();
        send_item(mk(F_WRITE, 24'hFFFFFF, 24'd2, 8'h00, 1'b0));
        send_item(mk(F_DATA, 24'h000000, 24'h000000, 8'hFF, 1'b0));
        send_item(mk(F_TICK, 24'h000000, 24'h000000, 8'h00, 1'b0));
        send_item(mk(F_RX, 24'h000000, 24'h000000, 8'h00, 1'b0));
        send_item(mk(F_DATA, 24'h000000, 24'h000000, 8'h00, 1'b0));
        send_item(mk(F_TICK, 24'h000000, 24'h000000, 8'h00, 1'b0));
        send_item(mk(F_RX, 24'h000000, 24'h000000, 8'hFE, 1'b0));
    endtask

    // With a zero program timeout the first tick after the chunk fails the program.
    task automatic test_zero_timeout();
        write_register(CFG_PROG_TO, 24'd0);
        send_item(mk(F_PROG, 24'h000000, 24'd1, 8'h00, 1'b0));
        send_item(mk(F_DATA, 24'h000000, 24'h000000, 8'hA5, 1'b0));
        send_item(mk(F_TICK, 24'h000000, 24'h000000, 8'h00, 1'b0));
    endtask

    // Random traffic: mostly complete operations, some stray items, until about
    // n more items have gone in.
    task automatic test_random_traffic(input int n);
        int goal;
        goal = items_sent + n;
        while (items_sent < goal) begin
            if ($urandom_range(99) < 8) begin
                send_item(mk(3'($urandom), 24'($urandom), 24'($urandom), 8'($urandom),
                             1'($urandom)));
            end else begin
                launch_request();
            end
            drive_to_idle();
        end
    endtask

    initial begin
        i_rst_n      <= 1'b0;
        i_cfg_we     <= 1'b0;
        i_cfg_index  <= CFG_PROG_TO;
        i_cfg_data   <= '0;
        i_valid      <= 1'b0;
        i_func       <= F_READ;
        i_addr       <= '0;
        i_length     <= '0;
        i_data_byte  <= '0;
        i_link_error <= 1'b0;
        i_stall      <= 1'b0;
        items_sent      = 0;
        results_checked = 0;
        mismatches      = 0;
        idle_cycles     = 0;
        reset_predictor();

        // The sender idles lightly and the receiver heavily for the directed part and
        // the first random stretch.
        tx_idle_pct = 22;
        rx_idle_pct = 74;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_zero_length_requests();
        test_stray_events();
        test_read_abort();
        test_id_check();
        test_erase_polling();
        test_write_page_wrap();
        test_zero_timeout();

        // Short timeouts make the poll limits bite; an all-zero id is expected.
        write_register(CFG_PROG_TO, 24'd1);
        write_register(CFG_ERASE_TO, 24'd2);
        write_register(CFG_EXP_ID, 24'h000000);
        test_random_traffic(130);

        // Swap the idling, take the largest program timeout and an all-ones id.
        write_register(CFG_PROG_TO, 24'd65535);
        write_register(CFG_ERASE_TO, 24'd1);
        write_register(CFG_EXP_ID, 24'hFFFFFF);
        tx_idle_pct = 74;
        rx_idle_pct = 22;
        test_random_traffic(130);

        // Full rate on both sides with the largest erase timeout.
        write_register(CFG_PROG_TO, 24'd3);
        write_register(CFG_ERASE_TO, 24'd65535);
        write_register(CFG_EXP_ID, 24'($urandom));
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_random_traffic(130);

        drain();
        repeat (30) @(posedge i_clk);

        $display("Sent %0d items (reads, erases, split writes, page programs, id checks)",
                 items_sent);
        $display("and checked %0d results under three stall mixes and four timeout setups.",
                 results_checked);
        if (mismatches == 0 && exp_actions.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
